### design/vrp_pkg.sv
// Package for the video register port: register codes, read source codes
// and the structs passed between the control and memory blocks.
// No dependencies; imported by every file but the two interfaces.
`timescale 1ns / 1ps
`default_nettype none

package vrp_pkg;

    typedef enum logic [2:0] {
        REG_CTRL     = 3'd0,
        REG_MASK     = 3'd1,
        REG_STATUS   = 3'd2,
        REG_OAM_ADDR = 3'd3,
        REG_OAM_DATA = 3'd4,
        REG_SCROLL   = 3'd5,
        REG_VADDR    = 3'd6,
        REG_VDATA    = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        RD_DIRECT = 2'd0,
        RD_VRAM   = 2'd1,
        RD_OAM    = 2'd2
    } rd_sel_t;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam int OAM_DEPTH = 256;
    localparam int OAM_AW    = 8;

    localparam int CTRL_INC_BIT  = 2;
    localparam int CTRL_NMI_BIT  = 7;
    localparam logic [7:0] FIRST_READ_VALUE = 8'hFF;
    localparam logic [7:0] STATUS_VBL_CLEAR = 8'h7F;
    localparam logic [15:0] STEP_ROW  = 16'd32;
    localparam logic [15:0] STEP_ONE  = 16'd1;

    // Nametable mirroring windows and palette mirror pairs.
    localparam logic [5:0]  NT_UPPER_LEFT  = 6'b001010;  // 0x2800-0x2BFF
    localparam logic [5:0]  NT_UPPER_RIGHT = 6'b001011;  // 0x2C00-0x2FFF
    localparam logic [15:0] NT_BASE_VERT   = 16'h2000;
    localparam logic [15:0] NT_BASE_HORZ   = 16'h2400;
    localparam logic [10:0] PAL_PREFIX     = 11'h1F8;    // 0x3F00-0x3F1F
    localparam logic [15:0] PAL_PAIR_FLIP  = 16'h0010;

    typedef struct packed {
        logic        vram_re;
        logic [15:0] vram_raddr;
        logic        vram_we;
        logic [15:0] vram_waddr;
        logic        pal_dual;
        logic [15:0] pal_addr2;
        logic [7:0]  wdata;
        logic        oam_re;
        logic        oam_we;
        logic [7:0]  oam_addr;
    } mem_req_t;

    typedef struct packed {
        logic clearing;
        logic second_busy;
    } mem_stat_t;

    typedef struct packed {
        rd_sel_t    sel;
        logic [7:0] value;
        logic       nmi;
    } rd_info_t;

endpackage

`default_nettype wire

### design/vrp_req_if.sv
// Request channel of the video register port: one CPU bus access per item.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface vrp_req_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [2:0] reg_index;
    logic [7:0] write_data;

    modport source (output valid, kind, reg_index, write_data, input ready);
    modport sink   (input valid, kind, reg_index, write_data, output ready);
endinterface

`default_nettype wire

### design/vrp_rsp_if.sv
// Response channel of the video register port: one result item per access.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface vrp_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       nmi_enable;

    modport source (output valid, read_data, nmi_enable, input ready);
    modport sink   (input valid, read_data, nmi_enable, output ready);
endinterface

`default_nettype wire

### design/vrp_ctrl.sv
// Register file and address logic of the video register port.
// Updates all register state when an item is accepted and issues memory requests.
// Depends on vrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vrp_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic              kind,
    input  wire logic [2:0]        reg_index,
    input  wire logic [7:0]        write_data,
    input  wire logic              mirror_vertical,
    output vrp_pkg::mem_req_t      mem_req,
    output vrp_pkg::rd_info_t      rd_info
);
    import vrp_pkg::*;

    logic [7:0]  control_reg, control_next;
    logic [7:0]  mask_reg, mask_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  sprite_addr_reg, sprite_addr_next;
    logic [7:0]  scroll_x_reg, scroll_x_next;
    logic [7:0]  scroll_y_reg, scroll_y_next;
    logic        scroll_toggle_reg, scroll_toggle_next;
    logic [15:0] addr_latch_reg, addr_latch_next;
    logic        addr_toggle_reg, addr_toggle_next;
    logic [15:0] data_addr_reg, data_addr_next;
    logic        loaded_reg, loaded_next;
    logic        pending_reg, pending_next;
    logic        first_read_reg, first_read_next;

    logic [15:0] step;
    logic [15:0] da;
    logic [15:0] waddr;
    logic        pal_hit;

    always_comb
    begin
        step = control_reg[CTRL_INC_BIT] ? STEP_ROW : STEP_ONE;
        control_next       = control_reg;
        mask_next          = mask_reg;
        status_next        = status_reg;
        sprite_addr_next   = sprite_addr_reg;
        scroll_x_next      = scroll_x_reg;
        scroll_y_next      = scroll_y_reg;
        scroll_toggle_next = scroll_toggle_reg;
        addr_latch_next    = addr_latch_reg;
        addr_toggle_next   = addr_toggle_reg;
        data_addr_next     = data_addr_reg;
        loaded_next        = loaded_reg;
        pending_next       = pending_reg;
        first_read_next    = first_read_reg;
        da      = data_addr_reg;
        waddr   = data_addr_reg;
        pal_hit = 1'b0;
        mem_req = '0;
        rd_info.sel   = RD_DIRECT;
        rd_info.value = 8'd0;

        if (kind == KIND_READ)
        begin
            case (reg_idx_t'(reg_index))
                REG_CTRL:     rd_info.value = control_reg;
                REG_MASK:     rd_info.value = mask_reg;
                REG_OAM_ADDR: rd_info.value = sprite_addr_reg;
                REG_STATUS:
                begin
                    rd_info.value      = status_reg;
                    scroll_toggle_next = 1'b0;
                    addr_toggle_next   = 1'b0;
                    addr_latch_next    = 16'd0;
                    status_next        = status_reg & STATUS_VBL_CLEAR;
                end
                REG_OAM_DATA:
                begin
                    rd_info.sel      = RD_OAM;
                    mem_req.oam_re   = accept;
                    mem_req.oam_addr = sprite_addr_reg;
                    sprite_addr_next = sprite_addr_reg + 8'd1;
                end
                REG_VDATA:
                begin
                    da                 = loaded_reg ? data_addr_reg : addr_latch_reg;
                    loaded_next        = 1'b1;
                    mem_req.vram_re    = accept;
                    mem_req.vram_raddr = da;
                    if (!first_read_reg)
                    begin
                        rd_info.sel    = RD_VRAM;
                        data_addr_next = pending_reg ? addr_latch_reg : da + step;
                        pending_next   = 1'b0;
                    end
                    else
                    begin
                        // The first data read only primes the address.
                        rd_info.value   = FIRST_READ_VALUE;
                        data_addr_next  = addr_latch_reg;
                        first_read_next = 1'b0;
                        pending_next    = 1'b0;
                    end
                end
                default: rd_info.value = 8'd0;
            endcase
        end
        else
        begin
            case (reg_idx_t'(reg_index))
                REG_CTRL:     control_next     = write_data;
                REG_MASK:     mask_next        = write_data;
                REG_STATUS:   status_next      = write_data;
                REG_OAM_ADDR: sprite_addr_next = write_data;
                REG_OAM_DATA:
                begin
                    mem_req.oam_we   = accept;
                    mem_req.oam_addr = sprite_addr_reg;
                    sprite_addr_next = sprite_addr_reg + 8'd1;
                end
                REG_SCROLL:
                begin
                    if (scroll_toggle_reg)
                        scroll_y_next = write_data;
                    else
                        scroll_x_next = write_data;
                    scroll_toggle_next = !scroll_toggle_reg;
                end
                REG_VADDR:
                begin
                    if (!addr_toggle_reg)
                    begin
                        addr_latch_next  = {write_data, 8'd0};
                        addr_toggle_next = 1'b1;
                    end
                    else
                    begin
                        addr_latch_next  = addr_latch_reg | {8'd0, write_data};
                        addr_toggle_next = 1'b0;
                    end
                    pending_next = 1'b1;
                end
                REG_VDATA:
                begin
                    if (pending_reg)
                    begin
                        da           = addr_latch_reg;
                        loaded_next  = 1'b1;
                        pending_next = 1'b0;
                    end
                    // Upper nametables fold onto the lower pair; palette
                    // backdrop entries are stored with their partner.
                    if (da[15:10] == NT_UPPER_LEFT)
                        waddr = (mirror_vertical ? NT_BASE_VERT : NT_BASE_HORZ)
                                | {6'd0, da[9:0]};
                    else if (da[15:10] == NT_UPPER_RIGHT)
                        waddr = NT_BASE_HORZ | {6'd0, da[9:0]};
                    else
                        waddr = da;
                    pal_hit = (da[15:5] == PAL_PREFIX) && (da[1:0] == 2'b00);
                    mem_req.vram_we    = accept;
                    mem_req.vram_waddr = waddr;
                    mem_req.pal_dual   = pal_hit;
                    mem_req.pal_addr2  = da ^ PAL_PAIR_FLIP;
                    mem_req.wdata      = write_data;
                    data_addr_next     = da + step;
                end
                default: mem_req.wdata = write_data;
            endcase
        end
        if (kind == KIND_WRITE)
            mem_req.wdata = write_data;
        rd_info.nmi = control_next[CTRL_NMI_BIT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg       <= 8'd0;
            mask_reg          <= 8'd0;
            status_reg        <= 8'd0;
            sprite_addr_reg   <= 8'd0;
            scroll_x_reg      <= 8'd0;
            scroll_y_reg      <= 8'd0;
            scroll_toggle_reg <= 1'b1;
            addr_latch_reg    <= 16'd0;
            addr_toggle_reg   <= 1'b0;
            data_addr_reg     <= 16'd0;
            loaded_reg        <= 1'b0;
            pending_reg       <= 1'b0;
            first_read_reg    <= 1'b1;
        end
        else if (accept)
        begin
            control_reg       <= control_next;
            mask_reg          <= mask_next;
            status_reg        <= status_next;
            sprite_addr_reg   <= sprite_addr_next;
            scroll_x_reg      <= scroll_x_next;
            scroll_y_reg      <= scroll_y_next;
            scroll_toggle_reg <= scroll_toggle_next;
            addr_latch_reg    <= addr_latch_next;
            addr_toggle_reg   <= addr_toggle_next;
            data_addr_reg     <= data_addr_next;
            loaded_reg        <= loaded_next;
            pending_reg       <= pending_next;
            first_read_reg    <= first_read_next;
        end
    end

endmodule

`default_nettype wire

### design/vrp_mem.sv
// Video and sprite memories of the video register port, with the clearing
// sweep after reset and the second write of a palette pair. Depends on vrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vrp_mem #(
    parameter int VRAM_DEPTH = 32768
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  vrp_pkg::mem_req_t      mem_req,
    output vrp_pkg::mem_stat_t     mem_stat,
    output logic [7:0]             vram_rdata,
    output logic [7:0]             oam_rdata
);
    import vrp_pkg::*;

    localparam int AW = $clog2(VRAM_DEPTH);
    localparam logic [17:0] D1 = 18'(VRAM_DEPTH);
    localparam logic [17:0] D2 = 18'(2 * VRAM_DEPTH);
    localparam logic [17:0] D3 = 18'(3 * VRAM_DEPTH);

    // Wrapping is exact for bus addresses below four times VRAM_DEPTH, as at
    // most three multiples are taken away.
    function automatic logic [AW-1:0] wrap_addr(input logic [15:0] a);
        logic [17:0] ax;
        logic [17:0] r;
        begin
            ax = {2'b00, a};
            if (ax >= D3)
                r = ax - D3;
            else if (ax >= D2)
                r = ax - D2;
            else if (ax >= D1)
                r = ax - D1;
            else
                r = ax;
            wrap_addr = r[AW-1:0];
        end
    endfunction

    logic [7:0] vram_mem [VRAM_DEPTH];
    logic [7:0] oam_mem  [OAM_DEPTH];

    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          clearing_reg, clearing_next;
    logic          pal2_valid_reg, pal2_valid_next;
    logic [AW-1:0] pal2_addr_reg;
    logic [7:0]    pal2_data_reg;
    logic [7:0]    vram_rdata_reg;
    logic [7:0]    oam_rdata_reg;

    logic          vram_we;
    logic [AW-1:0] vram_waddr;
    logic [7:0]    vram_wdata;
    logic          oam_we;
    logic [OAM_AW-1:0] oam_waddr;
    logic [7:0]    oam_wdata;

    always_comb
    begin
        clearing_next   = clearing_reg;
        clr_addr_next   = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(VRAM_DEPTH - 1))
                clearing_next = 1'b0;
        end
        pal2_valid_next = mem_req.vram_we && mem_req.pal_dual;

        if (clearing_reg)
        begin
            vram_we    = 1'b1;
            vram_waddr = clr_addr_reg;
            vram_wdata = 8'd0;
            oam_we     = 1'b1;
            oam_waddr  = clr_addr_reg[OAM_AW-1:0];
            oam_wdata  = 8'd0;
        end
        else
        begin
            vram_we    = pal2_valid_reg || mem_req.vram_we;
            vram_waddr = pal2_valid_reg ? pal2_addr_reg : wrap_addr(mem_req.vram_waddr);
            vram_wdata = pal2_valid_reg ? pal2_data_reg : mem_req.wdata;
            oam_we     = mem_req.oam_we;
            oam_waddr  = mem_req.oam_addr;
            oam_wdata  = mem_req.wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            pal2_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg   <= clearing_next;
            clr_addr_reg   <= clr_addr_next;
            pal2_valid_reg <= pal2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_req.vram_we)
        begin
            pal2_addr_reg <= wrap_addr(mem_req.pal_addr2);
            pal2_data_reg <= mem_req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vram_we)
            vram_mem[vram_waddr] <= vram_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_req.vram_re)
            vram_rdata_reg <= vram_mem[wrap_addr(mem_req.vram_raddr)];
    end

    always_ff @(posedge clk)
    begin
        if (oam_we)
            oam_mem[oam_waddr] <= oam_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_req.oam_re)
            oam_rdata_reg <= oam_mem[mem_req.oam_addr];
    end

    assign vram_rdata           = vram_rdata_reg;
    assign oam_rdata            = oam_rdata_reg;
    assign mem_stat.clearing    = clearing_reg;
    assign mem_stat.second_busy = pal2_valid_reg;

endmodule

`default_nettype wire

### design/video_register_port.sv
// Top level of the video register port: request and response channels,
// the mirroring register and a two-stage result path.
// Depends on vrp_pkg, vrp_req_if, vrp_rsp_if, vrp_ctrl and vrp_mem.
//
//   Channel   Direction  Carries
//   req       in         kind, reg_index, write_data (one bus access)
//   rsp       out        read_data, nmi_enable (one result per access)
//   cfg       in         cfg_we, cfg_wdata (mirror_vertical)
//
// One item is taken per cycle unless the clearing sweep, a palette second
// write or back-pressure holds it; a palette pair entry write drops
// req.ready while its partner uses the single video memory write port.
// A result is staged with the synchronous memory read, then registered for
// output; while it waits on rsp.ready a new item may still fill the stage.
// After reset the memories are swept to zero at all VRAM_DEPTH addresses
// (32768 by default) with req.ready low; configuration writes are taken.
`timescale 1ns / 1ps
`default_nettype none

module video_register_port #(
    parameter int VRAM_DEPTH = 32768
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    vrp_req_if.sink    req,
    vrp_rsp_if.source  rsp,
    input  wire logic  cfg_we,
    input  wire logic  cfg_wdata
);
    import vrp_pkg::*;

    logic       mirror_vertical_reg;
    logic       accept;
    logic       in_ready;
    logic       out_move;
    logic       s1_move;
    mem_req_t   mem_req;
    mem_stat_t  mem_stat;
    rd_info_t   rd_info;
    logic [7:0] vram_rdata;
    logic [7:0] oam_rdata;

    logic       s1_valid_reg, s1_valid_next;
    rd_info_t   s1_info_reg;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg, out_data_next;
    logic       out_nmi_reg;

    vrp_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .kind            (req.kind),
        .reg_index       (req.reg_index),
        .write_data      (req.write_data),
        .mirror_vertical (mirror_vertical_reg),
        .mem_req         (mem_req),
        .rd_info         (rd_info)
    );

    vrp_mem #(
        .VRAM_DEPTH (VRAM_DEPTH)
    ) u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .mem_req    (mem_req),
        .mem_stat   (mem_stat),
        .vram_rdata (vram_rdata),
        .oam_rdata  (oam_rdata)
    );

    always_comb
    begin
        out_move = !out_valid_reg || rsp.ready;
        s1_move  = s1_valid_reg && out_move;
        in_ready = !mem_stat.clearing && !mem_stat.second_busy
                   && (!s1_valid_reg || out_move);
        accept   = req.valid && in_ready;

        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_move)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        case (s1_info_reg.sel)
            RD_VRAM: out_data_next = vram_rdata;
            RD_OAM:  out_data_next = oam_rdata;
            default: out_data_next = s1_info_reg.value;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_vertical_reg <= 1'b0;
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mirror_vertical_reg <= cfg_wdata;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_info_reg <= rd_info;
        if (s1_move)
        begin
            out_data_reg <= out_data_next;
            out_nmi_reg  <= s1_info_reg.nmi;
        end
    end

    assign req.ready      = in_ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = out_data_reg;
    assign rsp.nmi_enable = out_nmi_reg;

`ifndef SYNTH
    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        mem_stat.clearing |-> !req.ready
    ) else $error("item accepted during the clearing sweep");

    a_palette_second_write: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && mem_req.vram_we && mem_req.pal_dual) |=> !req.ready
    ) else $error("item accepted while a palette partner write is pending");

    a_stage_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_move) |=> (s1_valid_reg && $stable(s1_info_reg))
    ) else $error("staged result lost while the output is stalled");
`endif

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for video_register_port: random and directed CPU bus
// accesses, checked against a behavioural prediction of the register file.
// Depends on vrp_pkg, vrp_req_if, vrp_rsp_if and the video_register_port RTL.
`timescale 1ns / 1ps

module tb;
    import vrp_pkg::*;

    localparam int VRAM_DEPTH  = 32768;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic       kind;
        reg_idx_t   reg_index;
        logic [7:0] write_data;
    } bus_access_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       nmi_enable;
    } port_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;

    logic        drv_valid = 1'b0;
    bus_access_t drv_item = '0;
    logic        sink_ready = 1'b0;

    vrp_req_if req_ch ();
    vrp_rsp_if rsp_ch ();

    assign req_ch.valid      = drv_valid;
    assign req_ch.kind       = drv_item.kind;
    assign req_ch.reg_index  = drv_item.reg_index;
    assign req_ch.write_data = drv_item.write_data;
    assign rsp_ch.ready      = sink_ready;

    video_register_port #(
        .VRAM_DEPTH (VRAM_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Predicted state of the register port.
    logic [7:0]  video_mem [VRAM_DEPTH];
    logic [7:0]  sprite_mem [OAM_DEPTH];
    logic [7:0]  ctrl_byte, mask_byte, status_byte, spr_addr;
    logic [7:0]  scroll_x_byte, scroll_y_byte;
    logic        scroll_phase, addr_phase;
    logic [15:0] vaddr_latch, vaddr;
    logic        vaddr_valid, latch_armed, first_data_read;
    logic        mirror_vert;

    bus_access_t  pending_accesses [$];
    port_result_t expected_results [$];
    port_result_t predicted, got_result, want_result;

    int send_idle_pct;
    int sink_idle_pct;
    int items_queued;
    int mismatch_count;
    int cycle_count;
    logic [15:0] last_video_addr;

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic void vram_put(input int a, input logic [7:0] v);
        video_mem[a % VRAM_DEPTH] = v;
    endfunction

    function automatic void store_video_byte(input logic [15:0] a, input logic [7:0] v);
        int ai;
        ai = int'(a);
        if (ai >= 'h2800 && ai < 'h2C00) begin
            vram_put((mirror_vert ? int'(NT_BASE_VERT) : int'(NT_BASE_HORZ)) + ai - 'h2800, v);
        end
        else if (ai >= 'h2C00 && ai < 'h3000) begin
            vram_put(int'(NT_BASE_HORZ) + ai - 'h2C00, v);
        end
        else if (a[15:4] == 12'h3F0 && a[1:0] == 2'b00) begin
            // Background palette entries share a cell with the sprite palette.
            vram_put(ai, v);
            vram_put(ai | int'(PAL_PAIR_FLIP), v);
        end
        else if (a[15:4] == 12'h3F1 && a[1:0] == 2'b00) begin
            vram_put(ai, v);
            vram_put(ai & ~int'(PAL_PAIR_FLIP), v);
        end
        else begin
            vram_put(ai, v);
        end
    endfunction

    function automatic port_result_t predict_access(input bus_access_t acc);
        port_result_t res;
        logic [7:0]   rd;
        logic [15:0]  step;
        rd = 8'h00;
        step = ctrl_byte[CTRL_INC_BIT] ? STEP_ROW : STEP_ONE;
        if (acc.kind == KIND_READ) begin
            case (acc.reg_index)
                REG_CTRL:     rd = ctrl_byte;
                REG_MASK:     rd = mask_byte;
                REG_OAM_ADDR: rd = spr_addr;
                REG_STATUS:
                begin
                    rd = status_byte;
                    scroll_phase = 1'b0;
                    addr_phase = 1'b0;
                    vaddr_latch = 16'h0000;
                    status_byte = status_byte & STATUS_VBL_CLEAR;
                end
                REG_OAM_DATA:
                begin
                    rd = sprite_mem[spr_addr];
                    spr_addr = spr_addr + 8'd1;
                end
                REG_VDATA:
                begin
                    if (!vaddr_valid) begin
                        vaddr = vaddr_latch;
                        vaddr_valid = 1'b1;
                    end
                    rd = video_mem[int'(vaddr) % VRAM_DEPTH];
                    if (!first_data_read) begin
                        vaddr = vaddr + step;
                        if (latch_armed) begin
                            vaddr = vaddr_latch;
                            latch_armed = 1'b0;
                        end
                    end
                    else begin
                        // The very first data read only primes the address.
                        rd = FIRST_READ_VALUE;
                        vaddr = vaddr_latch;
                        first_data_read = 1'b0;
                        latch_armed = 1'b0;
                    end
                end
                default: rd = 8'h00;
            endcase
        end
        else begin
            case (acc.reg_index)
                REG_CTRL:     ctrl_byte = acc.write_data;
                REG_MASK:     mask_byte = acc.write_data;
                REG_STATUS:   status_byte = acc.write_data;
                REG_OAM_ADDR: spr_addr = acc.write_data;
                REG_OAM_DATA:
                begin
                    sprite_mem[spr_addr] = acc.write_data;
                    spr_addr = spr_addr + 8'd1;
                end
                REG_SCROLL:
                begin
                    if (scroll_phase) begin
                        scroll_y_byte = acc.write_data;
                    end
                    else begin
                        scroll_x_byte = acc.write_data;
                    end
                    scroll_phase = ~scroll_phase;
                end
                REG_VADDR:
                begin
                    if (!addr_phase) begin
                        vaddr_latch = {acc.write_data, 8'h00};
                        addr_phase = 1'b1;
                    end
                    else begin
                        vaddr_latch = vaddr_latch | {8'h00, acc.write_data};
                        addr_phase = 1'b0;
                    end
                    latch_armed = 1'b1;
                end
                default:
                begin
                    if (latch_armed) begin
                        vaddr = vaddr_latch;
                        vaddr_valid = 1'b1;
                        latch_armed = 1'b0;
                    end
                    store_video_byte(vaddr, acc.write_data);
                    vaddr = vaddr + step;
                end
            endcase
        end
        res.read_data = rd;
        res.nmi_enable = ctrl_byte[CTRL_NMI_BIT];
        return res;
    endfunction

    task automatic push_access(input logic kind, input reg_idx_t r, input logic [7:0] d);
        bus_access_t acc;
        acc.kind = kind;
        acc.reg_index = r;
        acc.write_data = d;
        pending_accesses.push_back(acc);
        items_queued++;
    endtask

    function automatic logic [15:0] pick_video_address();
        logic [15:0] a;
        case ($urandom_range(6))
            0: a = 16'h2000 + 16'($urandom_range('h0FFF));
            1: a = 16'h2800 + 16'($urandom_range('h07FF));
            2: a = 16'h3F00 + 16'($urandom_range('h1F));
            3: a = {8'h3F, 3'b000, 3'($urandom_range(7)), 2'b00};
            4: a = 16'hFFFF - 16'($urandom_range(40));
            5: a = last_video_addr;
            default: a = 16'($urandom);
        endcase
        return a;
    endfunction

    // Mostly well-formed sequences (address set, then a data burst) with
    // random content; the rest is register traffic and plain noise.
    task automatic queue_random_traffic(input int count);
        int target;
        int burst;
        logic [15:0] a;
        target = items_queued + count;
        while (items_queued < target) begin
            case ($urandom_range(99)) inside
                [0:39]:
                begin
                    if ($urandom_range(9) < 7) begin
                        push_access(KIND_READ, REG_STATUS, 8'($urandom));
                    end
                    a = pick_video_address();
                    last_video_addr = a;
                    push_access(KIND_WRITE, REG_VADDR, a[15:8]);
                    push_access(KIND_WRITE, REG_VADDR, a[7:0]);
                    burst = $urandom_range(1, 6);
                    for (int i = 0; i < burst; i++) begin
                        push_access(logic'($urandom_range(1)), REG_VDATA, 8'($urandom));
                    end
                end
                [40:51]:
                begin
                    push_access(KIND_WRITE, REG_CTRL, 8'($urandom));
                    push_access(KIND_READ, REG_CTRL, 8'($urandom));
                end
                [52:66]:
                begin
                    push_access(KIND_WRITE, REG_OAM_ADDR, 8'($urandom));
                    burst = $urandom_range(1, 5);
                    for (int i = 0; i < burst; i++) begin
                        push_access(logic'($urandom_range(1)), REG_OAM_DATA, 8'($urandom));
                    end
                    push_access(KIND_READ, REG_OAM_ADDR, 8'($urandom));
                end
                [67:76]:
                begin
                    if ($urandom_range(1)) begin
                        push_access(KIND_READ, REG_STATUS, 8'($urandom));
                    end
                    push_access(KIND_WRITE, REG_SCROLL, 8'($urandom));
                    push_access(KIND_WRITE, REG_SCROLL, 8'($urandom));
                end
                [77:86]:
                begin
                    push_access(KIND_WRITE, REG_STATUS, 8'($urandom));
                    push_access(KIND_READ, REG_STATUS, 8'($urandom));
                    push_access(logic'($urandom_range(1)), REG_MASK, 8'($urandom));
                end
                default:
                begin
                    burst = $urandom_range(1, 4);
                    for (int i = 0; i < burst; i++) begin
                        push_access(logic'($urandom_range(1)), reg_idx_t'($urandom_range(7)),
                                    8'($urandom));
                    end
                end
            endcase
        end
    endtask

    task automatic wait_until_idle();
        do begin
            @(negedge clk);
        end while (pending_accesses.size() != 0 || drv_valid || expected_results.size() != 0);
    endtask

    task automatic write_mirroring(input logic vertical);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= vertical;
        mirror_vert = vertical;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Request driver: an item is presented when the queue has one and the
    // sender is not idling this cycle, and predicted when it is accepted.
    always @(posedge clk) begin
        if (!rst_n) begin
            drv_valid <= 1'b0;
        end
        else begin
            if (drv_valid && req_ch.ready) begin
                predicted = predict_access(drv_item);
                expected_results.push_back(predicted);
            end
            if (!drv_valid || req_ch.ready) begin
                if (pending_accesses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_item <= pending_accesses.pop_front();
                    drv_valid <= 1'b1;
                end
                else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor and receiver stalls.
    always @(posedge clk) begin
        if (!rst_n) begin
            sink_ready <= 1'b0;
        end
        else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got_result.read_data = rsp_ch.read_data;
                got_result.nmi_enable = rsp_ch.nmi_enable;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected result: read_data %02h nmi_enable %0d",
                                 got_result.read_data, got_result.nmi_enable);
                    end
                end
                else begin
                    want_result = expected_results.pop_front();
                    if (got_result.read_data !== want_result.read_data ||
                        got_result.nmi_enable !== want_result.nmi_enable) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch: expected read_data %02h nmi_enable %0d, got %02h %0d",
                                     want_result.read_data, want_result.nmi_enable,
                                     got_result.read_data, got_result.nmi_enable);
                        end
                    end
                end
            end
            sink_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < VRAM_DEPTH; i++) begin
            video_mem[i] = 8'h00;
        end
        for (int i = 0; i < OAM_DEPTH; i++) begin
            sprite_mem[i] = 8'h00;
        end
        ctrl_byte = 8'h00;
        mask_byte = 8'h00;
        status_byte = 8'h00;
        spr_addr = 8'h00;
        scroll_x_byte = 8'h00;
        scroll_y_byte = 8'h00;
        scroll_phase = 1'b1;
        addr_phase = 1'b0;
        vaddr_latch = 16'h0000;
        vaddr = 16'h0000;
        vaddr_valid = 1'b0;
        latch_armed = 1'b0;
        first_data_read = 1'b1;
        mirror_vert = 1'b0;
        items_queued = 0;
        mismatch_count = 0;
        cycle_count = 0;
        last_video_addr = 16'h2000;
        send_idle_pct = 7;
        sink_idle_pct = 81;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_mirroring(1'b0);
        // Register extremes, every register read and written, and the
        // first data read, sprite address wrap and write mirroring cases.
        push_access(KIND_READ,  REG_VDATA,    8'h00);
        push_access(KIND_WRITE, REG_CTRL,     8'h84);
        push_access(KIND_READ,  REG_CTRL,     8'h00);
        push_access(KIND_WRITE, REG_MASK,     8'hFF);
        push_access(KIND_READ,  REG_MASK,     8'h00);
        push_access(KIND_WRITE, REG_STATUS,   8'hFF);
        push_access(KIND_READ,  REG_STATUS,   8'h00);
        push_access(KIND_READ,  REG_STATUS,   8'h00);
        push_access(KIND_WRITE, REG_OAM_ADDR, 8'hFF);
        push_access(KIND_WRITE, REG_OAM_DATA, 8'h5A);
        push_access(KIND_WRITE, REG_OAM_ADDR, 8'hFF);
        push_access(KIND_READ,  REG_OAM_DATA, 8'h00);
        push_access(KIND_READ,  REG_OAM_ADDR, 8'h00);
        push_access(KIND_WRITE, REG_SCROLL,   8'h12);
        push_access(KIND_WRITE, REG_SCROLL,   8'h34);
        push_access(KIND_READ,  REG_SCROLL,   8'h00);
        push_access(KIND_READ,  REG_VADDR,    8'h00);
        push_access(KIND_WRITE, REG_VADDR,    8'h2C);
        push_access(KIND_WRITE, REG_VADDR,    8'h00);
        push_access(KIND_WRITE, REG_VDATA,    8'h00);
        push_access(KIND_WRITE, REG_VADDR,    8'h3F);
        push_access(KIND_WRITE, REG_VADDR,    8'h10);
        push_access(KIND_WRITE, REG_VDATA,    8'hFF);
        push_access(KIND_WRITE, REG_CTRL,     8'h00);
        push_access(KIND_WRITE, REG_VADDR,    8'h24);
        push_access(KIND_WRITE, REG_VADDR,    8'h00);
        push_access(KIND_READ,  REG_VDATA,    8'h00);
        push_access(KIND_READ,  REG_VDATA,    8'h00);
        wait_until_idle();

        write_mirroring(1'b1);
        push_access(KIND_READ,  REG_STATUS,   8'h00);
        push_access(KIND_WRITE, REG_VADDR,    8'h28);
        push_access(KIND_WRITE, REG_VADDR,    8'h00);
        push_access(KIND_WRITE, REG_VDATA,    8'h77);
        push_access(KIND_WRITE, REG_VADDR,    8'h20);
        push_access(KIND_WRITE, REG_VADDR,    8'h00);
        push_access(KIND_READ,  REG_VDATA,    8'h00);
        push_access(KIND_READ,  REG_VDATA,    8'h00);
        queue_random_traffic(400);
        wait_until_idle();

        send_idle_pct = 81;
        sink_idle_pct = 7;
        write_mirroring(1'b0);
        queue_random_traffic(400);
        wait_until_idle();

        send_idle_pct = 0;
        sink_idle_pct = 0;
        write_mirroring(1'b1);
        queue_random_traffic(400);
        wait_until_idle();

        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end
        else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### sim.f
design/vrp_pkg.sv
design/vrp_req_if.sv
design/vrp_rsp_if.sv
design/vrp_ctrl.sv
design/vrp_mem.sv
design/video_register_port.sv
tb/tb.sv
